// File: src/u8c_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 to cp1252 transcoder.
package u8c_pkg;

  localparam logic [7:0] UNMAPPED_CHAR = 8'h3F;
  localparam int unsigned MAX_RESULTS = 3;

  // Code points for cp1252 bytes 0x80..0x9F; zero marks an unused byte.
  localparam logic [15:0] HIGH_CTRL_MAP [32] = '{
    16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
    16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
  };

  // Results caused by one input byte, first result in bytes[0].
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            text_end;
  } grp_t;

  // Continuation bytes a lead asks for: 0 for ASCII, 1..3, or 4 if invalid.
  function automatic logic [2:0] lead_need(input logic [7:0] c);
    logic [2:0] n;
    if (!c[7]) begin
      n = 3'd0;
    end else if (c[7:5] == 3'b110) begin
      n = 3'd1;
    end else if (c[7:4] == 4'b1110) begin
      n = 3'd2;
    end else if (c[7:3] == 5'b11110) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  // A lone byte decodes to itself when ASCII and to the unmapped mark otherwise.
  function automatic logic [7:0] single_byte(input logic [7:0] c);
    return c[7] ? UNMAPPED_CHAR : c;
  endfunction

  // Map a code point to its cp1252 byte.
  function automatic logic [7:0] map_point(input logic [20:0] cp);
    logic [7:0] r;
    r = UNMAPPED_CHAR;
    if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
      r = cp[7:0];
    end else begin
      for (int j = 31; j >= 0; j--) begin
        if (HIGH_CTRL_MAP[j] != 16'h0000 && cp == {5'b0, HIGH_CTRL_MAP[j]}) begin
          r = {3'b100, 5'(j)};
        end
      end
    end
    return r;
  endfunction

endpackage

// File: src/u8c_assembler.sv
// Sequence assembler: buffers lead and continuation bytes and decodes finished runs.
module u8c_assembler (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_byte,
  input  logic          in_end,
  input  logic          take,
  output u8c_pkg::grp_t grp
);
  import u8c_pkg::*;

  logic [7:0] pend [3];
  logic [1:0] pend_cnt;
  logic [1:0] need_cnt;
  logic [1:0] pend_cnt_next;
  logic [1:0] need_cnt_next;
  logic       store;
  logic [2:0] c_need;
  logic [2:0] p1_need;
  logic [20:0] cp;
  logic [7:0]  mapped;

  assign c_need  = lead_need(in_byte);
  assign p1_need = lead_need(pend[1]);

  // Code point of a finished run, or of a two-byte run after a truncated lead.
  always_comb begin
    cp = {10'b0, pend[1][4:0], in_byte[5:0]};
    if (pend_cnt != 2'd0 && need_cnt == 2'd1) begin
      case (pend_cnt)
        2'd1:    cp = {10'b0, pend[0][4:0], in_byte[5:0]};
        2'd2:    cp = {5'b0, pend[0][3:0], pend[1][5:0], in_byte[5:0]};
        default: cp = {pend[0][2:0], pend[1][5:0], pend[2][5:0], in_byte[5:0]};
      endcase
    end
  end

  assign mapped = map_point(cp);

  // Decide between buffering the byte and emitting a result group.
  always_comb begin
    store         = 1'b0;
    pend_cnt_next = 2'd0;
    need_cnt_next = 2'd0;
    grp.count     = 2'd1;
    grp.bytes     = {UNMAPPED_CHAR, UNMAPPED_CHAR, UNMAPPED_CHAR};
    grp.text_end  = in_end;
    if (pend_cnt == 2'd0) begin
      if (c_need >= 3'd1 && c_need <= 3'd3 && !in_end) begin
        store         = 1'b1;
        pend_cnt_next = 2'd1;
        need_cnt_next = c_need[1:0];
        grp.count     = 2'd0;
      end else begin
        grp.bytes[0] = single_byte(in_byte);
      end
    end else if (need_cnt > 2'd1 && !in_end && pend_cnt < 2'd3) begin
      store         = 1'b1;
      pend_cnt_next = pend_cnt + 2'd1;
      need_cnt_next = need_cnt - 2'd1;
      grp.count     = 2'd0;
    end else if (need_cnt == 2'd1) begin
      // Complete sequence.
      grp.bytes[0] = mapped;
    end else if (pend_cnt == 2'd1) begin
      // Truncated lead, then the final byte on its own.
      grp.count    = 2'd2;
      grp.bytes[1] = single_byte(in_byte);
    end else begin
      // Truncated lead, then the buffered byte and the final byte decoded anew.
      if (p1_need == 3'd0) begin
        grp.count    = 2'd3;
        grp.bytes[1] = pend[1];
        grp.bytes[2] = single_byte(in_byte);
      end else if (p1_need == 3'd1) begin
        grp.count    = 2'd2;
        grp.bytes[1] = mapped;
      end else begin
        grp.count    = 2'd3;
        grp.bytes[2] = single_byte(in_byte);
      end
    end
  end

  // Pending counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
      need_cnt <= 2'd0;
    end else if (take) begin
      pend_cnt <= pend_cnt_next;
      need_cnt <= need_cnt_next;
    end
  end

  // Buffered bytes; only slots below the count are ever read.
  always_ff @(posedge clk) begin
    if (take && store) begin
      pend[pend_cnt] <= in_byte;
    end
  end

  a_need_with_pend: assert property (@(posedge clk) disable iff (rst)
    (pend_cnt != 2'd0) == (need_cnt != 2'd0))
    else $error("pending and needed counts disagree");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && in_end |=> pend_cnt == 2'd0)
    else $error("state not cleared after final byte");

  a_run_fits: assert property (@(posedge clk) disable iff (rst)
    pend_cnt != 2'd0 |-> ({1'b0, pend_cnt} + {1'b0, need_cnt}) <= 3'd4)
    else $error("pending run longer than four bytes");

endmodule

// File: src/u8c_emitter.sv
// Result register: holds one group of results and sends them out one per cycle while m_tready is high.
module u8c_emitter (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  u8c_pkg::grp_t grp,
  output logic          free,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,  // [7:0] out_byte
  output logic          m_tlast,  // run_last
  output logic          m_tuser   // [0] text_end
);
  import u8c_pkg::*;

  logic            valid;
  logic [1:0]      cnt;
  logic [1:0]      idx;
  logic [2:0][7:0] bytes;
  logic            text_end;
  logic            last;
  logic            fire;

  assign last     = (idx == cnt - 2'd1);
  assign fire     = valid && m_tready;
  assign free     = !valid || (fire && last);
  assign m_tvalid = valid;
  assign m_tdata  = bytes[idx];
  assign m_tlast  = last;
  assign m_tuser  = last && text_end;

  // Control: occupancy and read position.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (fire) begin
      if (last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Payload of the group.
  always_ff @(posedge clk) begin
    if (load) begin
      cnt      <= grp.count;
      bytes    <= grp.bytes;
      text_end <= grp.text_end;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> idx < cnt)
    else $error("read position past the group");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free && grp.count != 2'd0)
    else $error("group loaded over a pending one");

  a_idx_steps: assert property (@(posedge clk) disable iff (rst)
    fire && !last && !load |=> idx == $past(idx) + 2'd1)
    else $error("read position skipped");

endmodule

// File: src/utf8_to_cp1252_transcoder_top.sv
// Top level of the UTF-8 to cp1252 byte-stream transcoder.
// Takes one UTF-8 byte per cycle on the slave side when not stalled (s_tlast marks the final
// byte of a string) and returns cp1252 bytes on the master side. The input register and
// the result register work as two stages with the decode between them, so a byte whose
// request causes at most one result is taken every cycle while m_tready stays high. A byte
// that causes n results holds the result register until all n are sent; this happens
// only when a string ends inside a multi-byte sequence, where up to three results follow.
// m_tlast marks the last result of one input byte, and m_tuser marks the final result of
// the string. Bytes that open or extend an unfinished sequence produce nothing.
module utf8_to_cp1252_transcoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // string_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // [0] text_end
);
  import u8c_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_end;
  logic       consume;
  logic       out_free;
  grp_t       grp;

  assign consume  = in_full && (grp.count == 2'd0 || out_free);
  assign s_tready = !in_full || consume;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  u8c_assembler u_asm (
    .clk     (clk),
    .rst     (rst),
    .in_byte (in_byte),
    .in_end  (in_end),
    .take    (consume),
    .grp     (grp)
  );

  u8c_emitter u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (consume && grp.count != 2'd0),
    .grp      (grp),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
